@@ rtl/core/adm_pkg.sv @@
`timescale 1ns / 1ps

package adm_pkg;

  // axis counts of the pose and of the measured force
  localparam int NAX  = 6;
  localparam int NFRC = 3;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_INERTIA   = 3'd0;
  localparam logic [2:0] CFG_DAMPING   = 3'd1;
  localparam logic [2:0] CFG_STIFFNESS = 3'd2;
  localparam logic [2:0] CFG_FDZ       = 3'd3;
  localparam logic [2:0] CFG_TLIM      = 3'd4;
  localparam logic [2:0] CFG_RLIM      = 3'd5;
  localparam logic [2:0] CFG_TSTEP     = 3'd6;
  localparam logic [2:0] CFG_ENABLE    = 3'd7;

  // register reset values
  localparam logic [30:0] RST_INERTIA   = 31'd65536;
  localparam logic [30:0] RST_DAMPING   = 31'd65536;
  localparam logic [30:0] RST_STIFFNESS = 31'd65536;
  localparam logic [30:0] RST_FDZ       = 31'd6554;
  localparam logic [30:0] RST_TLIM      = 31'd6554;
  localparam logic [30:0] RST_RLIM      = 31'd6554;
  localparam logic [16:0] RST_TSTEP     = 17'd66;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_MUL,
    OP_SQACC,
    OP_SUMCLR,
    OP_DZSET,
    OP_NORM,
    OP_DIVR,
    OP_DIVA,
    OP_DIVSTEP,
    OP_KLOAD,
    OP_FSCALE,
    OP_NETINIT,
    OP_NETSUB,
    OP_ACCLOAD,
    OP_OFFUPD,
    OP_VELUPD,
    OP_LSET,
    OP_VSCALE,
    OP_OUT
  } op_e;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_FF,  // force * force
    MS_FK,  // force * ratio
    MS_DV,  // damping * velocity
    MS_SO,  // stiffness * offset
    MS_HV,  // time step * velocity
    MS_HA,  // time step * acceleration
    MS_VV,  // velocity * velocity
    MS_VK   // velocity * ratio
  } msel_e;

  typedef struct packed {
    op_e        op;
    msel_e      msel;
    logic [2:0] idx;
    logic       grp;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic dz_skip;
    logic norm_done;
    logic div_done;
    logic lim_over;
    logic out_free;
  } sts_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[31:0]);
    end
  endfunction

endpackage

@@ rtl/core/adm_ctrl.sv @@
`timescale 1ns / 1ps

module adm_ctrl #(
  parameter int AXES = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  adm_pkg::sts_t  sts_i,
  output adm_pkg::cmd_t  cmd_o
);
  import adm_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CLR   = 5'd1;
  localparam logic [4:0] ST_FSQ_M = 5'd2;
  localparam logic [4:0] ST_FSQ_A = 5'd3;
  localparam logic [4:0] ST_DZ    = 5'd4;
  localparam logic [4:0] ST_NORM  = 5'd5;
  localparam logic [4:0] ST_DIV   = 5'd6;
  localparam logic [4:0] ST_KLD   = 5'd7;
  localparam logic [4:0] ST_FS_M  = 5'd8;
  localparam logic [4:0] ST_FS_W  = 5'd9;
  localparam logic [4:0] ST_NET0  = 5'd10;
  localparam logic [4:0] ST_ND_M  = 5'd11;
  localparam logic [4:0] ST_ND_W  = 5'd12;
  localparam logic [4:0] ST_NS_M  = 5'd13;
  localparam logic [4:0] ST_NS_W  = 5'd14;
  localparam logic [4:0] ST_ADIV  = 5'd15;
  localparam logic [4:0] ST_ACC   = 5'd16;
  localparam logic [4:0] ST_HV_M  = 5'd17;
  localparam logic [4:0] ST_HV_W  = 5'd18;
  localparam logic [4:0] ST_HA_M  = 5'd19;
  localparam logic [4:0] ST_HA_W  = 5'd20;
  localparam logic [4:0] ST_LIM   = 5'd21;
  localparam logic [4:0] ST_LSQ_M = 5'd22;
  localparam logic [4:0] ST_LSQ_A = 5'd23;
  localparam logic [4:0] ST_LSET  = 5'd24;
  localparam logic [4:0] ST_LS_M  = 5'd25;
  localparam logic [4:0] ST_LS_W  = 5'd26;
  localparam logic [4:0] ST_OUT   = 5'd27;

  // last axis of each group, limited by the axis count
  localparam int TLAST_I = (AXES - 1 < 2) ? AXES - 1 : 2;
  localparam int RLAST_I = (AXES - 1 < 5) ? AXES - 1 : 5;
  localparam logic [2:0] TLAST  = 3'(TLAST_I);
  localparam logic [2:0] RLAST  = 3'(RLAST_I);
  localparam logic [2:0] AXLAST = 3'(AXES - 1);
  localparam logic       RSKIP  = (AXES <= 3);
  localparam logic [2:0] RFIRST = 3'd3;

  logic [4:0] st_q, st_d;
  logic [2:0] idx_q, idx_d;
  logic       grp_q, grp_d;
  logic       lim_q, lim_d;
  logic       adiv_q, adiv_d;
  logic [2:0] glast;

  assign glast      = grp_q ? RLAST : TLAST;
  assign in_stall_o = (st_q != ST_IDLE);

  // sequencer
  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    grp_d  = grp_q;
    lim_d  = lim_q;
    adiv_d = adiv_q;
    cmd_o  = '{op: OP_NONE, msel: MS_FF, idx: idx_q, grp: grp_q};
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          idx_d    = 3'd0;
          grp_d    = 1'b0;
          lim_d    = 1'b0;
          st_d     = sts_i.enable ? ST_FSQ_M : ST_CLR;
        end
      end
      ST_CLR: begin
        cmd_o.op = OP_CLR;
        st_d     = ST_OUT;
      end
      ST_FSQ_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_FF;
        st_d       = ST_FSQ_A;
      end
      ST_FSQ_A: begin
        cmd_o.op = OP_SQACC;
        if (idx_q == TLAST) begin
          st_d = ST_DZ;
        end else begin
          idx_d = idx_q + 3'd1;
          st_d  = ST_FSQ_M;
        end
      end
      ST_DZ: begin
        cmd_o.op = OP_DZSET;
        idx_d    = 3'd0;
        st_d     = sts_i.dz_skip ? ST_NET0 : ST_NORM;
      end
      ST_NORM: begin
        if (sts_i.norm_done) begin
          cmd_o.op = OP_DIVR;
          adiv_d   = 1'b0;
          st_d     = ST_DIV;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          st_d = adiv_q ? ST_ACC : ST_KLD;
        end else begin
          cmd_o.op = OP_DIVSTEP;
        end
      end
      ST_KLD: begin
        cmd_o.op = OP_KLOAD;
        if (lim_q) begin
          idx_d = grp_q ? RFIRST : 3'd0;
          st_d  = ST_LS_M;
        end else begin
          idx_d = 3'd0;
          st_d  = ST_FS_M;
        end
      end
      // force scaling after the dead zone
      ST_FS_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_FK;
        st_d       = ST_FS_W;
      end
      ST_FS_W: begin
        cmd_o.op = OP_FSCALE;
        if (idx_q == 3'(NFRC - 1)) begin
          idx_d = 3'd0;
          st_d  = ST_NET0;
        end else begin
          idx_d = idx_q + 3'd1;
          st_d  = ST_FS_M;
        end
      end
      // per axis euler step
      ST_NET0: begin
        cmd_o.op = OP_NETINIT;
        st_d     = ST_ND_M;
      end
      ST_ND_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_DV;
        st_d       = ST_ND_W;
      end
      ST_ND_W: begin
        cmd_o.op = OP_NETSUB;
        st_d     = ST_NS_M;
      end
      ST_NS_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_SO;
        st_d       = ST_NS_W;
      end
      ST_NS_W: begin
        cmd_o.op = OP_NETSUB;
        st_d     = ST_ADIV;
      end
      ST_ADIV: begin
        cmd_o.op = OP_DIVA;
        adiv_d   = 1'b1;
        st_d     = ST_DIV;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACCLOAD;
        st_d     = ST_HV_M;
      end
      ST_HV_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_HV;
        st_d       = ST_HV_W;
      end
      ST_HV_W: begin
        cmd_o.op = OP_OFFUPD;
        st_d     = ST_HA_M;
      end
      ST_HA_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_HA;
        st_d       = ST_HA_W;
      end
      ST_HA_W: begin
        cmd_o.op = OP_VELUPD;
        if (idx_q == AXLAST) begin
          grp_d = 1'b0;
          lim_d = 1'b1;
          st_d  = ST_LIM;
        end else begin
          idx_d = idx_q + 3'd1;
          st_d  = ST_NET0;
        end
      end
      // speed limit of one velocity group
      ST_LIM: begin
        cmd_o.op = OP_SUMCLR;
        if (grp_q && RSKIP) begin
          st_d = ST_OUT;
        end else begin
          idx_d = grp_q ? RFIRST : 3'd0;
          st_d  = ST_LSQ_M;
        end
      end
      ST_LSQ_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_VV;
        st_d       = ST_LSQ_A;
      end
      ST_LSQ_A: begin
        cmd_o.op = OP_SQACC;
        if (idx_q == glast) begin
          st_d = ST_LSET;
        end else begin
          idx_d = idx_q + 3'd1;
          st_d  = ST_LSQ_M;
        end
      end
      ST_LSET: begin
        cmd_o.op = OP_LSET;
        if (sts_i.lim_over) begin
          st_d = ST_NORM;
        end else if (grp_q) begin
          st_d = ST_OUT;
        end else begin
          grp_d = 1'b1;
          st_d  = ST_LIM;
        end
      end
      ST_LS_M: begin
        cmd_o.op   = OP_MUL;
        cmd_o.msel = MS_VK;
        st_d       = ST_LS_W;
      end
      ST_LS_W: begin
        cmd_o.op = OP_VSCALE;
        if (idx_q != glast) begin
          idx_d = idx_q + 3'd1;
          st_d  = ST_LS_M;
        end else if (grp_q) begin
          st_d = ST_OUT;
        end else begin
          grp_d = 1'b1;
          st_d  = ST_LIM;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      idx_q  <= 3'd0;
      grp_q  <= 1'b0;
      lim_q  <= 1'b0;
      adiv_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      grp_q  <= grp_d;
      lim_q  <= lim_d;
      adiv_q <= adiv_d;
    end
  end

endmodule

@@ rtl/core/adm_dp.sv @@
`timescale 1ns / 1ps

module adm_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adm_pkg::cmd_t       cmd_i,
  output adm_pkg::sts_t       sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  input  logic signed [31:0]  set_i [adm_pkg::NAX],
  input  logic signed [31:0]  frc_i [adm_pkg::NFRC],
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  cmd_o [adm_pkg::NAX],
  output logic signed [31:0]  vel_o [adm_pkg::NAX]
);
  import adm_pkg::*;

  localparam int DQW  = 32 + FRAC_BITS;
  localparam int KW   = FRAC_BITS + 1;
  localparam int CNTW = $clog2(DQW + 1);

  // configuration
  logic [30:0] inertia_q, damping_q, stiff_q, fdz_q, tlim_q, rlim_q;
  logic [16:0] tstep_q;
  logic        enable_q;

  // controller state
  logic signed [31:0] off_q [NAX];
  logic signed [31:0] vel_q [NAX];
  logic               out_valid_q;
  logic [CNTW-1:0]    cnt_q;

  // working registers
  logic signed [31:0] set_q [NAX];
  logic signed [31:0] frc_q [NFRC];
  logic signed [63:0] prod_q;
  logic [63:0]        sum_q, num_q, den_q;
  logic [KW-1:0]      k_q;
  logic signed [63:0] net_q;
  logic signed [31:0] acc_q;
  logic [DQW-1:0]     dvd_q;
  logic [31:0]        rem_q, dvs_q;
  logic               neg_q;
  logic signed [31:0] cmdr_q [NAX];
  logic signed [31:0] velr_q [NAX];

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [63:0] psh;
  logic signed [31:0] frc_sel, vel_sel, off_sel;
  logic [63:0]        dz, blim;
  logic [32:0]        dtry;
  logic               dge;
  logic signed [31:0] net_sat;
  logic [31:0]        net_mag;
  logic signed [63:0] quo_s;

  assign frc_sel = frc_q[cmd_i.idx[1:0]];
  assign vel_sel = vel_q[cmd_i.idx];
  assign off_sel = off_q[cmd_i.idx];
  assign psh     = prod_q >>> FRAC_BITS;

  // shared multiplier operands
  always_comb begin
    case (cmd_i.msel)
      MS_FF: begin ma = 33'(frc_sel); mb = 33'(frc_sel); end
      MS_FK: begin ma = 33'(frc_sel); mb = signed'(33'(k_q)); end
      MS_DV: begin ma = signed'({2'b00, damping_q}); mb = 33'(vel_sel); end
      MS_SO: begin ma = signed'({2'b00, stiff_q}); mb = 33'(off_sel); end
      MS_HV: begin ma = signed'({16'd0, tstep_q}); mb = 33'(vel_sel); end
      MS_HA: begin ma = signed'({16'd0, tstep_q}); mb = 33'(acc_q); end
      MS_VV: begin ma = 33'(vel_sel); mb = 33'(vel_sel); end
      MS_VK: begin ma = 33'(vel_sel); mb = signed'(33'(k_q)); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = ma * mb;

  // dead zone and speed limit thresholds
  assign dz   = 64'(fdz_q) << FRAC_BITS;
  assign blim = 64'(cmd_i.grp ? rlim_q : tlim_q) << FRAC_BITS;

  // one restoring divider step
  assign dtry = {rem_q, dvd_q[DQW-1]};
  assign dge  = (dtry >= {1'b0, dvs_q});

  // acceleration divide operands
  assign net_sat = sat32(net_q);
  assign net_mag = net_sat[31] ? 32'(-33'(net_sat)) : 32'(net_sat);
  assign quo_s   = neg_q ? -signed'(64'(dvd_q)) : signed'(64'(dvd_q));

  // status to the controller
  assign sts_o.enable    = enable_q;
  assign sts_o.dz_skip   = (sum_q < dz) || (sum_q == 64'd0);
  assign sts_o.norm_done = (den_q[63:32] == 32'd0);
  assign sts_o.div_done  = (cnt_q == '0);
  assign sts_o.lim_over  = (sum_q > blim);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inertia_q <= RST_INERTIA;
      damping_q <= RST_DAMPING;
      stiff_q   <= RST_STIFFNESS;
      fdz_q     <= RST_FDZ;
      tlim_q    <= RST_TLIM;
      rlim_q    <= RST_RLIM;
      tstep_q   <= RST_TSTEP;
      enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INERTIA:   inertia_q <= cfg_data_i;
        CFG_DAMPING:   damping_q <= cfg_data_i;
        CFG_STIFFNESS: stiff_q   <= cfg_data_i;
        CFG_FDZ:       fdz_q     <= cfg_data_i;
        CFG_TLIM:      tlim_q    <= cfg_data_i;
        CFG_RLIM:      rlim_q    <= cfg_data_i;
        CFG_TSTEP:     tstep_q   <= cfg_data_i[16:0];
        CFG_ENABLE:    enable_q  <= cfg_data_i[0];
        default:       enable_q  <= enable_q;
      endcase
    end
  end

  // offset and velocity state, output valid, divider count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        off_q[i] <= '0;
        vel_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLR: begin
          for (int i = 0; i < NAX; i++) begin
            off_q[i] <= '0;
            vel_q[i] <= '0;
          end
        end
        OP_OFFUPD: off_q[cmd_i.idx] <= sat32(64'(off_sel) + psh);
        OP_VELUPD: vel_q[cmd_i.idx] <= sat32(64'(vel_sel) + psh);
        OP_VSCALE: vel_q[cmd_i.idx] <= signed'(psh[31:0]);
        OP_DIVR, OP_DIVA: cnt_q <= CNTW'(DQW);
        OP_DIVSTEP: cnt_q <= cnt_q - 1'b1;
        OP_OUT: out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mp[63:0];
    case (cmd_i.op)
      OP_LOAD: begin
        set_q <= set_i;
        frc_q <= frc_i;
        sum_q <= '0;
      end
      OP_SQACC:  sum_q <= sum_q + prod_q;
      OP_SUMCLR: sum_q <= '0;
      OP_DZSET: begin
        num_q <= sum_q - dz;
        den_q <= sum_q;
        if (sts_o.dz_skip) begin
          for (int j = 0; j < NFRC; j++) begin
            frc_q[j] <= '0;
          end
        end
      end
      OP_LSET: begin
        num_q <= blim;
        den_q <= sum_q;
      end
      OP_NORM: begin
        num_q <= num_q >> 1;
        den_q <= den_q >> 1;
      end
      OP_DIVR: begin
        dvd_q <= {num_q[31:0], {FRAC_BITS{1'b0}}};
        dvs_q <= den_q[31:0];
        rem_q <= '0;
        neg_q <= 1'b0;
      end
      OP_DIVA: begin
        dvd_q <= {net_mag, {FRAC_BITS{1'b0}}};
        dvs_q <= (inertia_q == 31'd0) ? 32'd1 : {1'b0, inertia_q};
        rem_q <= '0;
        neg_q <= net_sat[31];
      end
      OP_DIVSTEP: begin
        rem_q <= dge ? 32'(dtry - {1'b0, dvs_q}) : dtry[31:0];
        dvd_q <= {dvd_q[DQW-2:0], dge};
      end
      OP_KLOAD:   k_q <= dvd_q[KW-1:0];
      OP_FSCALE:  frc_q[cmd_i.idx[1:0]] <= signed'(psh[31:0]);
      OP_NETINIT: net_q <= (cmd_i.idx < 3'(NFRC)) ? 64'(frc_sel) : 64'sd0;
      OP_NETSUB:  net_q <= net_q - psh;
      OP_ACCLOAD: acc_q <= sat32(quo_s);
      OP_OUT: begin
        for (int i = 0; i < NAX; i++) begin
          cmdr_q[i] <= sat32(64'(set_q[i]) + 64'(off_q[i]));
          velr_q[i] <= vel_q[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmdr_q;
  assign vel_o       = velr_q;

endmodule

@@ rtl/core/admittance_control_step.sv @@
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// input     | in_valid_i / in_stall_o   | set_x_i .. set_rz_i, force_x_i .. force_z_i
// output    | out_valid_o / out_stall_i | cmd_x_o .. cmd_rz_o, vel_x_o .. vel_rz_o
// config    | cfg_we_i                  | cfg_idx_i, cfg_data_i
// a disabled request clears the offset and velocity and goes straight to the output;
// an enabled one is paced by the shared divider that retires one quotient bit per cycle
// one request is worked at a time; the next is taken while a result waits
// in the output register, and a stalled output only holds the finish step
// reset clears the configuration to its defaults and the offset and velocity

module admittance_control_step #(
  parameter int AXES      = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] set_x_i,
  input  logic signed [31:0] set_y_i,
  input  logic signed [31:0] set_z_i,
  input  logic signed [31:0] set_rx_i,
  input  logic signed [31:0] set_ry_i,
  input  logic signed [31:0] set_rz_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic signed [31:0] force_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] cmd_x_o,
  output logic signed [31:0] cmd_y_o,
  output logic signed [31:0] cmd_z_o,
  output logic signed [31:0] cmd_rx_o,
  output logic signed [31:0] cmd_ry_o,
  output logic signed [31:0] cmd_rz_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] vel_rx_o,
  output logic signed [31:0] vel_ry_o,
  output logic signed [31:0] vel_rz_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  import adm_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] set_v [NAX];
  logic signed [31:0] frc_v [NFRC];
  logic signed [31:0] cmd_v [NAX];
  logic signed [31:0] vel_v [NAX];

  // gather the request fields
  assign set_v = '{set_x_i, set_y_i, set_z_i, set_rx_i, set_ry_i, set_rz_i};
  assign frc_v = '{force_x_i, force_y_i, force_z_i};

  adm_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .set_i       (set_v),
    .frc_i       (frc_v),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd_v),
    .vel_o       (vel_v)
  );

  // spread the result fields
  assign cmd_x_o  = cmd_v[0];
  assign cmd_y_o  = cmd_v[1];
  assign cmd_z_o  = cmd_v[2];
  assign cmd_rx_o = cmd_v[3];
  assign cmd_ry_o = cmd_v[4];
  assign cmd_rz_o = cmd_v[5];
  assign vel_x_o  = vel_v[0];
  assign vel_y_o  = vel_v[1];
  assign vel_z_o  = vel_v[2];
  assign vel_rx_o = vel_v[3];
  assign vel_ry_o = vel_v[4];
  assign vel_rz_o = vel_v[5];

endmodule

@@ rtl/core/adm_checker.sv @@
`timescale 1ns / 1ps

module adm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] cmd_x_o,
  input logic signed [31:0] vel_x_o
);

  // a taken request keeps the input stalled while it is worked
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // finishing a request always leaves a result
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("request finished without a result");

  // a new result only appears as the block goes idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while still busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(cmd_x_o) && $stable(vel_x_o)))
    else $error("stalled result changed");

endmodule

bind admittance_control_step adm_checker u_adm_checker (.*);

@@ tb/admittance_control_step_checker.sv @@
`timescale 1ns / 1ps

module admittance_control_step_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic signed [31:0] set_x_i,
  input  logic signed [31:0] set_y_i,
  input  logic signed [31:0] set_z_i,
  input  logic signed [31:0] set_rx_i,
  input  logic signed [31:0] set_ry_i,
  input  logic signed [31:0] set_rz_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic signed [31:0] force_z_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [31:0] cmd_x_o,
  input  logic signed [31:0] cmd_y_o,
  input  logic signed [31:0] cmd_z_o,
  input  logic signed [31:0] cmd_rx_o,
  input  logic signed [31:0] cmd_ry_o,
  input  logic signed [31:0] cmd_rz_o,
  input  logic signed [31:0] vel_x_o,
  input  logic signed [31:0] vel_y_o,
  input  logic signed [31:0] vel_z_o,
  input  logic signed [31:0] vel_rx_o,
  input  logic signed [31:0] vel_ry_o,
  input  logic signed [31:0] vel_rz_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  output int                 fail_count,
  output int                 pending
);
  import adm_pkg::*;

  localparam int FB = 16;

  // shadow configuration
  longint unsigned inertia, damping, stiffness, fdz_lim, trans_lim, rot_lim, tstep;
  logic            enabled;

  // shadow offset and velocity
  longint offset_st[6];
  longint speed_st[6];

  // expected pose commands and velocities, oldest first
  logic [11:0][31:0] pose_q[$];

  // running mismatch count
  int fails;
  assign fail_count = fails;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor of x / 2^FB
  function automatic longint qshift(longint v);
    return v >>> FB;
  endfunction

  // floor(2^FB * n / d) after bringing d below 2^32
  function automatic longint unsigned scale_ratio(longint unsigned n, longint unsigned d);
    while (d >= 64'h1_0000_0000) begin
      n = n >> 1;
      d = d >> 1;
    end
    return (n << FB) / d;
  endfunction

  function automatic longint unsigned triple_len2(longint a, longint b, longint c);
    longint unsigned s;
    s = longint'(a * a);
    s = s + longint'(b * b) + longint'(c * c);
    return s;
  endfunction

  // bound one velocity triple by limit over squared length
  task automatic bound_speed(input int first, input longint unsigned lim);
    longint unsigned s, b;
    longint k;
    s = triple_len2(speed_st[first], speed_st[first+1], speed_st[first+2]);
    b = lim << FB;
    if (s > b) begin
      k = longint'(scale_ratio(b, s));
      for (int i = first; i < first + 3; i++) speed_st[i] = qshift(speed_st[i] * k);
    end
  endtask

  // one euler step of the mass-damper-spring model
  task automatic admit_step(input longint setp[6], input longint frc_in[3],
                            output logic [11:0][31:0] res);
    longint frc[6];
    longint new_off[6], new_vel[6];
    longint unsigned len2, dz;
    longint m, h, net, acc, k;
    for (int i = 0; i < 6; i++) frc[i] = 0;
    if (!enabled) begin
      for (int i = 0; i < 6; i++) begin
        offset_st[i] = 0;
        speed_st[i] = 0;
      end
    end else begin
      m = (inertia != 0) ? longint'(inertia) : 1;
      h = longint'(tstep);
      // dead zone on squared force length
      len2 = triple_len2(frc_in[0], frc_in[1], frc_in[2]);
      dz = fdz_lim << FB;
      if (len2 >= dz && len2 != 0) begin
        k = longint'(scale_ratio(len2 - dz, len2));
        for (int i = 0; i < 3; i++) frc[i] = qshift(frc_in[i] * k);
      end
      for (int i = 0; i < 6; i++) begin
        net = frc[i] - qshift(longint'(damping) * speed_st[i])
                     - qshift(longint'(stiffness) * offset_st[i]);
        net = clamp32(net);
        acc = clamp32((net * (64'sd1 << FB)) / m);
        new_off[i] = clamp32(offset_st[i] + qshift(h * speed_st[i]));
        new_vel[i] = clamp32(speed_st[i] + qshift(h * acc));
      end
      for (int i = 0; i < 6; i++) begin
        offset_st[i] = new_off[i];
        speed_st[i] = new_vel[i];
      end
      bound_speed(0, trans_lim);
      bound_speed(3, rot_lim);
    end
    for (int i = 0; i < 6; i++) begin
      res[i] = 32'(clamp32(setp[i] + offset_st[i]));
      res[6+i] = 32'(speed_st[i]);
    end
  endtask

  task automatic report(input int field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on output field %0d at %0t: got %h, want %h", field, $realtime, got,
             want);
    fails++;
  endtask

  logic [11:0][31:0] seen;
  assign seen = {vel_rz_o, vel_ry_o, vel_rx_o, vel_z_o, vel_y_o, vel_x_o,
                 cmd_rz_o, cmd_ry_o, cmd_rx_o, cmd_z_o, cmd_y_o, cmd_x_o};

  // watch config writes, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    longint setp[6];
    longint frc[3];
    logic [11:0][31:0] res;
    logic [11:0][31:0] want;
    if (!rst_ni) begin
      inertia   = 64'(RST_INERTIA);
      damping   = 64'(RST_DAMPING);
      stiffness = 64'(RST_STIFFNESS);
      fdz_lim   = 64'(RST_FDZ);
      trans_lim = 64'(RST_TLIM);
      rot_lim   = 64'(RST_RLIM);
      tstep     = 64'(RST_TSTEP);
      enabled   = 1'b0;
      for (int i = 0; i < 6; i++) begin
        offset_st[i] = 0;
        speed_st[i] = 0;
      end
      pose_q.delete();
      pending <= 0;
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INERTIA:   inertia = 64'(cfg_data_i);
          CFG_DAMPING:   damping = 64'(cfg_data_i);
          CFG_STIFFNESS: stiffness = 64'(cfg_data_i);
          CFG_FDZ:       fdz_lim = 64'(cfg_data_i);
          CFG_TLIM:      trans_lim = 64'(cfg_data_i);
          CFG_RLIM:      rot_lim = 64'(cfg_data_i);
          CFG_TSTEP:     tstep = 64'(cfg_data_i[16:0]);
          default:       enabled = cfg_data_i[0];
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        setp = '{64'(set_x_i), 64'(set_y_i), 64'(set_z_i),
                 64'(set_rx_i), 64'(set_ry_i), 64'(set_rz_i)};
        frc = '{64'(force_x_i), 64'(force_y_i), 64'(force_z_i)};
        admit_step(setp, frc, res);
        pose_q.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fails++;
        end else begin
          want = pose_q.pop_front();
          for (int i = 0; i < 12; i++)
            if (seen[i] !== want[i]) report(i, seen[i], want[i]);
        end
      end
      pending <= pose_q.size();
    end
  end

endmodule

@@ tb/admittance_control_step_test.sv @@
`timescale 1ns / 1ps

module admittance_control_step_test;
  import adm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] set_x_i = '0, set_y_i = '0, set_z_i = '0;
  logic signed [31:0] set_rx_i = '0, set_ry_i = '0, set_rz_i = '0;
  logic signed [31:0] force_x_i = '0, force_y_i = '0, force_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] cmd_x_o, cmd_y_o, cmd_z_o, cmd_rx_o, cmd_ry_o, cmd_rz_o;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o, vel_rx_o, vel_ry_o, vel_rz_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [30:0]        cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  logic               hold_go = 1'b0;
  int                 burst_left = 0;

  admittance_control_step dut (.*);
  admittance_control_step_checker checker_i (.*);

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result stall pattern with one long hold-off on request
  always @(posedge clk_i) begin
    int mode_left, mode, hold_left;
    bit held;
    if (hold_go && !held) begin
      held = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(200, 30);
        mode = $urandom_range(2, 0);
      end
      mode_left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3, 0) == 0);
        default: out_stall_i <= ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input longint unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 31'(val);
    @(posedge clk_i);
  endtask

  // drain outstanding requests, then load a full register set
  task automatic set_config(input longint unsigned m, d, s, dz, tl, rl, ts, en);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_write(CFG_INERTIA, m);
    cfg_write(CFG_DAMPING, d);
    cfg_write(CFG_STIFFNESS, s);
    cfg_write(CFG_FDZ, dz);
    cfg_write(CFG_TLIM, tl);
    cfg_write(CFG_RLIM, rl);
    cfg_write(CFG_TSTEP, ts);
    cfg_write(CFG_ENABLE, en);
    cfg_we_i <= 1'b0;
    burst_left = 0;
  endtask

  // offer one request and wait until taken; valid stays up for the next one
  task automatic send_request(input logic [31:0] sp[6], input logic [31:0] f[3]);
    in_valid_i <= 1'b1;
    {set_x_i, set_y_i, set_z_i} <= {sp[0], sp[1], sp[2]};
    {set_rx_i, set_ry_i, set_rz_i} <= {sp[3], sp[4], sp[5]};
    {force_x_i, force_y_i, force_z_i} <= {f[0], f[1], f[2]};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // bursts of back-to-back requests with random gaps
  task automatic paced_request(input logic [31:0] sp[6], input logic [31:0] f[3]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_request(sp, f);
  endtask

  // mostly small magnitudes, sometimes the full range
  function automatic logic [31:0] rand_word();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65535, 0)) - 32768);
      default: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
    endcase
  endfunction

  task automatic random_requests(input int n);
    logic [31:0] sp[6];
    logic [31:0] f[3];
    for (int k = 0; k < n; k++) begin
      foreach (sp[i]) sp[i] = rand_word();
      foreach (f[i]) f[i] = rand_word();
      paced_request(sp, f);
    end
  endtask

  task automatic fixed_request(input logic [31:0] s, input logic [31:0] fx, fy, fz);
    logic [31:0] sp[6];
    logic [31:0] f[3];
    foreach (sp[i]) sp[i] = s;
    f = '{fx, fy, fz};
    send_request(sp, f);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled at reset: command follows set point, velocity zero
    fixed_request(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0);
    fixed_request(32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff);

    // enabled at defaults: zero force, force inside dead zone, extremes
    set_config(65536, 65536, 65536, 6554, 6554, 6554, 66, 1);
    fixed_request(32'h0, 32'h0, 32'h0, 32'h0);
    fixed_request(32'h10000, 32'h1000, 32'hfffff000, 32'h0);
    fixed_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    fixed_request(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    fixed_request(32'h7fff0000, 32'h00100000, 32'hfff00000, 32'h00050000);

    // extremes: tiny mass, large step, open limits, no dead zone
    set_config(1, 31'h7fffffff, 0, 0, 31'h7fffffff, 31'h7fffffff, 65536, 1);
    fixed_request(32'h12345678, 32'h7fffffff, 32'h80000000, 32'h1);
    fixed_request(32'h80000000, 32'h1, 32'h0, 32'h0);
    fixed_request(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    random_requests(6);

    // zero mass, zero limits, large dead zone, shortest step
    set_config(0, 0, 31'h7fffffff, 31'h7fffffff, 0, 0, 1, 1);
    fixed_request(32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    fixed_request(32'h55555555, 32'h00030000, 32'h0, 32'h0);

    // frozen state with zero step, step width over 17 bits, heavy mass
    set_config(31'h7fffffff, 1000, 1000, 100, 100, 100, 31'h7ffe0000, 1);
    fixed_request(32'haaaaaaaa, 32'h00200000, 32'h0, 32'h0);
    set_config(31'h7fffffff, 1000, 1000, 100, 100, 100, 65536, 1);
    fixed_request(32'haaaaaaaa, 32'h00200000, 32'h7fffffff, 32'h0);

    // random phases; the first one carries the long output hold-off
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: set_config(65536, 65536, 65536, 6554, 6554, 6554, 66, 1);
        1: set_config($urandom_range(300000, 1), $urandom_range(300000, 0),
                      $urandom_range(300000, 0), $urandom_range(20000, 0),
                      $urandom_range(300000, 0), $urandom_range(300000, 0),
                      $urandom_range(65536, 1), 1);
        2: set_config($urandom & 31'h7fffffff, $urandom & 31'h7fffffff,
                      $urandom & 31'h7fffffff, $urandom & 31'h7fffffff,
                      $urandom & 31'h7fffffff, $urandom & 31'h7fffffff,
                      $urandom_range(65536, 0), 1);
        default: set_config(65536, 65536, 65536, 6554, 6554, 6554, 66,
                            (p == 3) ? 0 : 1);
      endcase
      if (p == 0) hold_go <= 1'b1;
      random_requests(50);
    end

    // finish: wait for every result, then let the block settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
